FILE: rtl/core/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    localparam int DATA_W  = 16;               // Q2.14 field width
    localparam int ARG_W   = 18;               // trace / root argument, signed
    localparam int NUM_W   = 17;               // off-diagonal sum or difference
    localparam int RAD_W   = 32;               // radicand a << 14
    localparam int ROOT_W  = 16;               // floor(sqrt(radicand))
    localparam int STEPS   = RAD_W / 2;        // one root bit per stage
    localparam int FRAC_SH = 13;               // num * 8192
    localparam int DVD_W   = NUM_W + FRAC_SH;  // dividend magnitude width
    localparam int QUO_W   = 23;               // root >= 128 bounds the quotient
    localparam int CMP_W   = DVD_W + ROOT_W;   // shifted divisor width
    localparam int ONE_Q14 = 16384;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
        logic [1:0]               branch_used;
        logic                     degenerate;
    } t_quat;

    // travels alongside the root
    typedef struct packed {
        logic [1:0]              br;
        logic                    degen;
        logic signed [NUM_W-1:0] num0;
        logic signed [NUM_W-1:0] num1;
        logic signed [NUM_W-1:0] num2;
    } t_side;

    // travels alongside the quotients
    typedef struct packed {
        logic [1:0]        br;
        logic              degen;
        logic [ROOT_W-2:0] half;
    } t_dside;

endpackage

`default_nettype wire

FILE: rtl/core/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Trace, branch choice, root argument and off-diagonal numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire rmq_pkg::t_mat               i_mat,
    output logic                             o_valid,
    output logic [rmq_pkg::RAD_W-1:0]        o_rad,
    output rmq_pkg::t_side                   o_side
);
    import rmq_pkg::*;

    logic signed [ARG_W-1:0] e00, e11, e22, trace, arg;
    logic signed [NUM_W-1:0] d_x, d_y, d_z, s_xy, s_xz, s_yz;
    logic [1:0]              br;
    t_side                   n_side;
    logic [RAD_W-1:0]        n_rad;
    logic                    r_valid;
    logic [RAD_W-1:0]        r_rad;
    t_side                   r_side;

    assign e00   = ARG_W'(i_mat.m00);
    assign e11   = ARG_W'(i_mat.m11);
    assign e22   = ARG_W'(i_mat.m22);
    assign trace = e00 + e11 + e22;

    assign d_x  = NUM_W'(i_mat.m21) - NUM_W'(i_mat.m12);
    assign d_y  = NUM_W'(i_mat.m02) - NUM_W'(i_mat.m20);
    assign d_z  = NUM_W'(i_mat.m10) - NUM_W'(i_mat.m01);
    assign s_xy = NUM_W'(i_mat.m01) + NUM_W'(i_mat.m10);
    assign s_xz = NUM_W'(i_mat.m02) + NUM_W'(i_mat.m20);
    assign s_yz = NUM_W'(i_mat.m12) + NUM_W'(i_mat.m21);

    always_comb begin
        if (trace > 0) begin
            br = BR_TRACE;
        end else if (e00 > e11 && e00 > e22) begin
            br = BR_X;
        end else if (e11 > e22) begin
            br = BR_Y;
        end else begin
            br = BR_Z;
        end

        n_side.br = br;
        case (br)
            BR_TRACE: begin
                arg = trace + ARG_W'(ONE_Q14);
                n_side.num0 = d_x;
                n_side.num1 = d_y;
                n_side.num2 = d_z;
            end
            BR_X: begin
                arg = ARG_W'(ONE_Q14) + e00 - e11 - e22;
                n_side.num0 = s_xy;
                n_side.num1 = s_xz;
                n_side.num2 = d_x;
            end
            BR_Y: begin
                arg = ARG_W'(ONE_Q14) + e11 - e00 - e22;
                n_side.num0 = s_xy;
                n_side.num1 = s_yz;
                n_side.num2 = d_y;
            end
            default: begin
                arg = ARG_W'(ONE_Q14) + e22 - e00 - e11;
                n_side.num0 = s_xz;
                n_side.num1 = s_yz;
                n_side.num2 = d_z;
            end
        endcase

        n_side.degen = (arg <= 0);
        // radicand is arg in Q.28
        n_rad = n_side.degen ? '0 : {{(RAD_W-ARG_W-14+1){1'b0}}, arg[ARG_W-2:0], 14'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rad  <= n_rad;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

`default_nettype wire

FILE: rtl/core/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [rmq_pkg::RAD_W-1:0]   i_rad,
    input  wire rmq_pkg::t_side              i_side,
    output logic                             o_valid,
    output logic [rmq_pkg::ROOT_W-1:0]       o_root,
    output rmq_pkg::t_side                   o_side
);
    import rmq_pkg::*;

    logic [RAD_W-1:0] r_n   [STEPS];
    logic [RAD_W-1:0] r_res [STEPS];
    t_side            r_side[STEPS];
    logic [STEPS-1:0] r_vld;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [RAD_W-1:0] BIT_K = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        logic [RAD_W-1:0] n_cur, res_cur, trial, n_n, n_res;
        logic             vld_cur;
        t_side            side_cur;

        if (k == 0) begin : g_first
            assign n_cur    = i_rad;
            assign res_cur  = '0;
            assign vld_cur  = i_valid;
            assign side_cur = i_side;
        end else begin : g_next
            assign n_cur    = r_n[k-1];
            assign res_cur  = r_res[k-1];
            assign vld_cur  = r_vld[k-1];
            assign side_cur = r_side[k-1];
        end

        assign trial = res_cur + BIT_K;

        always_comb begin
            if (n_cur >= trial) begin
                n_n   = n_cur - trial;
                n_res = (res_cur >> 1) + BIT_K;
            end else begin
                n_n   = n_cur;
                n_res = res_cur >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_cur;
            end
            if (i_en) begin
                r_n[k]    <= n_n;
                r_res[k]  <= n_res;
                r_side[k] <= side_cur;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_res[STEPS-1][ROOT_W-1:0];
    assign o_side  = r_side[STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/core/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three restoring dividers in lockstep: (num * 8192) / root, one quotient bit
// per stage, magnitude with a separate sign.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [rmq_pkg::ROOT_W-1:0]  i_root,
    input  wire rmq_pkg::t_side              i_side,
    output logic                             o_valid,
    output logic [rmq_pkg::QUO_W-1:0]        o_quo [3],
    output logic [2:0]                       o_neg,
    output rmq_pkg::t_dside                  o_dside
);
    import rmq_pkg::*;

    logic [DVD_W-1:0]  r_rem  [QUO_W][3];
    logic [QUO_W-1:0]  r_quo  [QUO_W][3];
    logic [2:0]        r_neg  [QUO_W];
    logic [ROOT_W-1:0] r_root [QUO_W];
    t_dside            r_ds   [QUO_W];
    logic [QUO_W-1:0]  r_vld;

    logic [DVD_W-1:0]  in_rem [3];
    logic [2:0]        in_neg;
    logic [NUM_W-1:0]  in_mag [3];
    logic signed [NUM_W-1:0] in_num [3];
    t_dside            in_ds;

    assign in_num[0] = i_side.num0;
    assign in_num[1] = i_side.num1;
    assign in_num[2] = i_side.num2;

    for (genvar j = 0; j < 3; j++) begin : g_lane_in
        assign in_neg[j] = in_num[j][NUM_W-1];
        assign in_mag[j] = in_neg[j] ? NUM_W'(-in_num[j]) : NUM_W'(in_num[j]);
        assign in_rem[j] = {in_mag[j], {FRAC_SH{1'b0}}};
    end

    assign in_ds.br    = i_side.br;
    assign in_ds.degen = i_side.degen;
    assign in_ds.half  = i_root[ROOT_W-1:1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int SH = QUO_W - 1 - k;
        logic [DVD_W-1:0]  rem_cur [3];
        logic [QUO_W-1:0]  quo_cur [3];
        logic [2:0]        neg_cur;
        logic [ROOT_W-1:0] root_cur;
        t_dside            ds_cur;
        logic              vld_cur;
        logic [CMP_W-1:0]  dsh;

        if (k == 0) begin : g_first
            assign rem_cur  = in_rem;
            assign quo_cur  = '{default: '0};
            assign neg_cur  = in_neg;
            assign root_cur = i_root;
            assign ds_cur   = in_ds;
            assign vld_cur  = i_valid;
        end else begin : g_next
            assign rem_cur  = r_rem[k-1];
            assign quo_cur  = r_quo[k-1];
            assign neg_cur  = r_neg[k-1];
            assign root_cur = r_root[k-1];
            assign ds_cur   = r_ds[k-1];
            assign vld_cur  = r_vld[k-1];
        end

        assign dsh = CMP_W'(root_cur) << SH;

        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [CMP_W-1:0] rem_ext, diff;
            logic             take;
            assign rem_ext = CMP_W'(rem_cur[j]);
            assign take    = (rem_ext >= dsh);
            assign diff    = rem_ext - dsh;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][j] <= take ? diff[DVD_W-1:0] : rem_cur[j];
                    r_quo[k][j] <= quo_cur[j] | (QUO_W'(take) << SH);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_cur;
            end
            if (i_en) begin
                r_neg[k]  <= neg_cur;
                r_root[k] <= root_cur;
                r_ds[k]   <= ds_cur;
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_neg   = r_neg[QUO_W-1];
    assign o_dside = r_ds[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/rmq_out.sv
// ----------------------------------------------------------------------------
// rmq_out
// Saturation, component placement by branch, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_stall,
    input  wire logic                        i_valid,
    input  wire logic [rmq_pkg::QUO_W-1:0]   i_quo [3],
    input  wire logic [2:0]                  i_neg,
    input  wire rmq_pkg::t_dside             i_dside,
    output logic                             o_en,
    output logic                             o_valid,
    output rmq_pkg::t_quat                   o_quat
);
    import rmq_pkg::*;

    logic [DATA_W-1:0] sat [3];
    logic [DATA_W-1:0] half;
    t_quat             n_quat;
    t_quat             r_quat;
    logic              r_valid;

    localparam logic [QUO_W-1:0] POS_MAX = QUO_W'(32767);
    localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'(32768);

    for (genvar j = 0; j < 3; j++) begin : g_sat
        always_comb begin
            if (i_neg[j]) begin
                sat[j] = (i_quo[j] > NEG_MAX) ? 16'h8000 : DATA_W'(-i_quo[j]);
            end else begin
                sat[j] = (i_quo[j] > POS_MAX) ? 16'h7fff : i_quo[j][DATA_W-1:0];
            end
        end
    end

    assign half = DATA_W'(i_dside.half);

    always_comb begin
        n_quat.branch_used = i_dside.br;
        n_quat.degenerate  = i_dside.degen;
        case (i_dside.br)
            BR_TRACE: begin
                n_quat.quat_x = sat[0];
                n_quat.quat_y = sat[1];
                n_quat.quat_z = sat[2];
                n_quat.quat_w = half;
            end
            BR_X: begin
                n_quat.quat_x = half;
                n_quat.quat_y = sat[0];
                n_quat.quat_z = sat[1];
                n_quat.quat_w = sat[2];
            end
            BR_Y: begin
                n_quat.quat_x = sat[0];
                n_quat.quat_y = half;
                n_quat.quat_z = sat[1];
                n_quat.quat_w = sat[2];
            end
            default: begin
                n_quat.quat_x = sat[0];
                n_quat.quat_y = sat[1];
                n_quat.quat_z = half;
                n_quat.quat_w = sat[2];
            end
        endcase
        if (i_dside.degen) begin
            n_quat.quat_x = '0;
            n_quat.quat_y = '0;
            n_quat.quat_z = '0;
            n_quat.quat_w = '0;
        end
    end

    // whole pipe freezes while a held beat is refused
    assign o_en = !(r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
        if (o_en) begin
            r_quat <= n_quat;
        end
    end

    assign o_valid = r_valid;
    assign o_quat  = r_quat;

endmodule

`default_nettype wire

FILE: rtl/core/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd conversion of a Q2.14 rotation matrix to a Q2.14 quaternion.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with the nine matrix entries in i_mat.
// Output channel: o_valid / i_stall with x, y, z, w, the branch taken and a
// degenerate flag in o_quat.
// An accepted beat reaches its result on o_valid through
// one front stage (trace, branch, root argument), 16 square-root stages,
// 23 divider stages (three lanes, one quotient bit per stage) and the
// output register. Throughput is one beat per cycle while the pipe is not held.
// Reset (synchronous, active low) clears every valid bit; data registers
// are not reset and the pipe is empty afterward.
// While a result sits in the output register and i_stall is high, the
// whole pipe holds and o_stall is raised; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire rmq_pkg::t_mat     i_mat,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output rmq_pkg::t_quat         o_quat
);
    import rmq_pkg::*;

    logic              en;
    logic              f_valid, s_valid, d_valid;
    logic [RAD_W-1:0]  f_rad;
    t_side             f_side, s_side;
    logic [ROOT_W-1:0] s_root;
    logic [QUO_W-1:0]  d_quo [3];
    logic [2:0]        d_neg;
    t_dside            d_dside;

    assign o_stall = !en;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_mat   (i_mat),
        .o_valid (f_valid),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_side  (s_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_neg   (d_neg),
        .o_dside (d_dside)
    );

    rmq_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stall (i_stall),
        .i_valid (d_valid),
        .i_quo   (d_quo),
        .i_neg   (d_neg),
        .i_dside (d_dside),
        .o_en    (en),
        .o_valid (o_valid),
        .o_quat  (o_quat)
    );

endmodule

`default_nettype wire
